FILE: design/signed_shift_subtract_divider_macros.svh
// assertion macros used by the divider's top module
`ifndef SIGNED_SHIFT_SUBTRACT_DIVIDER_MACROS_SVH
`define SIGNED_SHIFT_SUBTRACT_DIVIDER_MACROS_SVH

// same-cycle implication, checked outside reset
`define SSD_ASSERT_NOW(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("ssd check failed");

// next-cycle implication, checked outside reset
`define SSD_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("ssd check failed");

`endif

FILE: design/ssd_pkg.sv
// types and constants of the signed shift-subtract divider
`default_nettype none

package ssd_pkg;

  localparam int WIDTH = 32;

  typedef logic [WIDTH-1:0] word_t;

  localparam word_t MOST_NEG = {1'b1, {(WIDTH-1){1'b0}}};
  localparam word_t MOST_POS = ~MOST_NEG;
  localparam word_t ALL_ONES = {WIDTH{1'b1}};

  // input item
  typedef struct packed {
    logic signed [WIDTH-1:0] dividend;
    logic signed [WIDTH-1:0] divisor;
  } req_item_t;

  // result item
  typedef struct packed {
    logic signed [WIDTH-1:0] quotient;
    logic                    overflowed;
    logic                    divide_by_zero;
  } rsp_item_t;

  // state carried down the pipeline
  // nq holds the dividend bits still to use on the left, quotient bits on the right
  typedef struct packed {
    word_t rem;
    word_t nq;
    word_t den;
    logic  neg;
    logic  ovf;
    logic  dbz;
  } work_t;

endpackage

`default_nettype wire

FILE: design/signed_shift_subtract_divider.sv
// Signed 32-bit divider, quotient truncated toward zero, no remainder. Each item
// passes through one register stage that forms the operand magnitudes, 32 restoring
// shift-subtract stages that each settle one quotient bit, and a last stage that
// applies the sign and drives the output register. The stages form
// one pipeline, so a new item is taken in every cycle in which the output is not
// held; while a result waits under rsp_stall the whole pipeline freezes and
// req_stall is raised. A zero divisor gives quotient 0 with divide_by_zero set;
// the most negative value divided by minus one gives the largest positive value
// with overflowed set.
`default_nettype none
`include "signed_shift_subtract_divider_macros.svh"

module signed_shift_subtract_divider
  import ssd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_stall,
  input  wire req_item_t req_item,
  output logic           rsp_valid,
  input  wire logic      rsp_stall,
  output rsp_item_t      rsp_item
);

  logic  adv;
  logic  valid [WIDTH+1];
  work_t work  [WIDTH+1];

  // pipeline moves unless a finished item is held at the output
  assign adv       = !(rsp_valid && rsp_stall);
  assign req_stall = !adv;

  // operand preparation
  ssd_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (req_valid),
    .in_item   (req_item),
    .out_valid (valid[0]),
    .out_work  (work[0])
  );

  // one quotient bit per stage, most significant first
  for (genvar i = 0; i < WIDTH; i++) begin : g_step
    ssd_step u_step (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (valid[i]),
      .in_work   (work[i]),
      .out_valid (valid[i+1]),
      .out_work  (work[i+1])
    );
  end

  // sign and output
  ssd_fix u_fix (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (valid[WIDTH]),
    .in_work   (work[WIDTH]),
    .out_valid (rsp_valid),
    .out_item  (rsp_item)
  );

  // checks
  `SSD_ASSERT_NOW(a_flags_excl, clk, rst, rsp_valid,
    !(rsp_item.overflowed && rsp_item.divide_by_zero))
  `SSD_ASSERT_NOW(a_dbz_zero, clk, rst, rsp_valid && rsp_item.divide_by_zero,
    rsp_item.quotient == '0)
  `SSD_ASSERT_NOW(a_ovf_sat, clk, rst, rsp_valid && rsp_item.overflowed,
    word_t'(rsp_item.quotient) == MOST_POS)
  `SSD_ASSERT_NOW(a_backpressure, clk, rst, rsp_valid && rsp_stall, req_stall)
  `SSD_ASSERT_NEXT(a_held_tail, clk, rst, valid[WIDTH] && rsp_valid && rsp_stall,
    valid[WIDTH])

endmodule

`default_nettype wire

FILE: design/ssd_prep.sv
// first stage: operand magnitudes, result sign and special cases
`default_nettype none

module ssd_prep
  import ssd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      adv,
  input  wire logic      in_valid,
  input  wire req_item_t in_item,
  output logic           out_valid,
  output work_t          out_work
);

  word_t a;
  word_t b;
  logic  a_neg;
  logic  b_neg;
  work_t work_next;

  // magnitudes and flags
  always_comb begin
    a     = word_t'(in_item.dividend);
    b     = word_t'(in_item.divisor);
    a_neg = a[WIDTH-1];
    b_neg = b[WIDTH-1];
    work_next.rem = '0;
    work_next.nq  = a_neg ? word_t'(-a) : a;
    work_next.den = b_neg ? word_t'(-b) : b;
    work_next.neg = a_neg ^ b_neg;
    work_next.dbz = (b == '0);
    work_next.ovf = (a == MOST_NEG) && (b == ALL_ONES);
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      out_work <= work_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/ssd_step.sv
// one restoring division stage: one quotient bit
`default_nettype none

module ssd_step
  import ssd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  adv,
  input  wire logic  in_valid,
  input  wire work_t in_work,
  output logic       out_valid,
  output work_t      out_work
);

  logic [WIDTH:0] trial;
  logic [WIDTH:0] diff;
  logic           take;
  work_t          work_next;

  // shift in the next dividend bit, trial subtract
  always_comb begin
    trial     = {in_work.rem, in_work.nq[WIDTH-1]};
    diff      = trial - {1'b0, in_work.den};
    take      = !diff[WIDTH];
    work_next = in_work;
    work_next.rem = take ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
    work_next.nq  = {in_work.nq[WIDTH-2:0], take};
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      out_work <= work_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/ssd_fix.sv
// last stage: apply sign, special cases, output register
`default_nettype none

module ssd_fix
  import ssd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  adv,
  input  wire logic  in_valid,
  input  wire work_t in_work,
  output logic       out_valid,
  output rsp_item_t  out_item
);

  word_t     q;
  rsp_item_t item_next;

  // signed quotient with overrides
  always_comb begin
    q = in_work.neg ? word_t'(-in_work.nq) : in_work.nq;
    item_next.overflowed     = in_work.ovf;
    item_next.divide_by_zero = in_work.dbz;
    priority if (in_work.dbz) begin
      item_next.quotient = '0;
    end else if (in_work.ovf) begin
      item_next.quotient = MOST_POS;
    end else begin
      item_next.quotient = q;
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      out_item <= item_next;
    end
  end

endmodule

`default_nettype wire

FILE: sim/tb.sv
// testbench for the signed shift-subtract divider: random and directed items, self-checking
`default_nettype none

module tb
  import ssd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_ITEMS = 450;
  localparam int unsigned DRAIN_CYCLES = 60;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_item_t req_item = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_item_t rsp_item;

  req_item_t   pending_divs[$];
  rsp_item_t   expected_quotients[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  logic        req_fired = 1'b0;

  signed_shift_subtract_divider u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_item  (req_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // quotient truncated toward zero, with the saturation and zero-divisor flags
  function automatic rsp_item_t divide_truncated(req_item_t it);
    rsp_item_t res;
    word_t     num;
    word_t     den;
    word_t     num_mag;
    word_t     den_mag;
    word_t     part;
    word_t     quo;
    int        i;
    res = '0;
    num = it.dividend;
    den = it.divisor;
    if (den == '0) begin
      res.divide_by_zero = 1'b1;
      return res;
    end
    if (num == MOST_NEG && den == ALL_ONES) begin
      res.quotient   = MOST_POS;
      res.overflowed = 1'b1;
      return res;
    end
    num_mag = num[WIDTH-1] ? word_t'(-num) : num;
    den_mag = den[WIDTH-1] ? word_t'(-den) : den;
    part = '0;
    quo  = '0;
    // restoring division, one quotient bit per step from the top
    for (i = WIDTH - 1; i >= 0; i--) begin
      part = {part[WIDTH-2:0], num_mag[i]};
      quo  = {quo[WIDTH-2:0], 1'b0};
      if (part >= den_mag) begin
        part   = part - den_mag;
        quo[0] = 1'b1;
      end
    end
    if (num[WIDTH-1] != den[WIDTH-1]) quo = -quo;
    res.quotient = quo;
    return res;
  endfunction

  // operand drawn from a mix of full-width, short, tiny and boundary values
  function automatic word_t pick_operand();
    word_t v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = $urandom();
      3, 4: begin
        v = $urandom() >> $urandom_range(1, 31);
        if ($urandom_range(0, 1)) v = -v;
      end
      5, 6: begin
        v = $urandom_range(0, 300);
        if ($urandom_range(0, 1)) v = -v;
      end
      7: begin
        case ($urandom_range(0, 4))
          0: v = '0;
          1: v = word_t'(1);
          2: v = ALL_ONES;
          3: v = MOST_NEG;
          default: v = MOST_POS;
        endcase
      end
      default: begin
        v = $urandom() >> $urandom_range(16, 31);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // calm stretches with no idling on either side
  function automatic logic calm_phase();
    return cycle_count[8:7] == 2'b00;
  endfunction

  task automatic add_div(word_t a, word_t b);
    req_item_t it;
    it.dividend = a;
    it.divisor  = b;
    pending_divs.push_back(it);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  // sender: holds an item until taken, then waits out a random gap
  always @(negedge clk) begin
    logic      nxt_valid;
    req_item_t nxt_item;
    nxt_valid = req_valid;
    nxt_item  = req_item;
    if (!rst) begin
      if (req_valid && !req_fired) begin
        nxt_valid = 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
        nxt_valid = 1'b0;
      end else if (pending_divs.size() > 0) begin
        nxt_item  = pending_divs.pop_front();
        nxt_valid = 1'b1;
        send_gap  = calm_phase() ? 0 : pick_idle();
      end else begin
        nxt_valid = 1'b0;
      end
    end
    req_valid <= nxt_valid;
    req_item  <= nxt_item;
  end

  // receiver stall, in bursts of random length
  always @(negedge clk) begin
    logic nxt_stall;
    nxt_stall = 1'b0;
    if (!rst) begin
      if (stall_left > 0) begin
        stall_left--;
        nxt_stall = 1'b1;
      end else if (!calm_phase() && $urandom_range(0, 99) < 20) begin
        stall_left = pick_idle();
        nxt_stall  = 1'b1;
      end
    end
    rsp_stall <= nxt_stall;
  end

  // monitor: predict on every taken item, check every taken result
  always @(posedge clk) begin
    rsp_item_t want;
    req_fired = 1'b0;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        req_fired = 1'b1;
        expected_quotients.push_back(divide_truncated(req_item));
      end
      if (rsp_valid && !rsp_stall) begin
        if (expected_quotients.size() == 0) begin
          report_mismatch("unexpected item, quotient", rsp_item.quotient, 0);
        end else begin
          want = expected_quotients.pop_front();
          if (rsp_item.quotient !== want.quotient)
            report_mismatch("quotient", rsp_item.quotient, want.quotient);
          if (rsp_item.overflowed !== want.overflowed)
            report_mismatch("overflowed", rsp_item.overflowed, want.overflowed);
          if (rsp_item.divide_by_zero !== want.divide_by_zero)
            report_mismatch("divide_by_zero", rsp_item.divide_by_zero, want.divide_by_zero);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    int unsigned n;
    // directed: signs, extremes and the special cases
    add_div('0, word_t'(5));
    add_div('0, -word_t'(5));
    add_div(MOST_NEG, ALL_ONES);
    add_div(MOST_NEG, word_t'(1));
    add_div(word_t'(5), '0);
    add_div(MOST_NEG, '0);
    add_div('0, '0);
    add_div(MOST_POS, word_t'(1));
    add_div(MOST_POS, ALL_ONES);
    add_div(MOST_POS, MOST_NEG);
    add_div(MOST_NEG, MOST_NEG);
    add_div(MOST_NEG, MOST_POS);
    add_div(MOST_POS, MOST_POS);
    add_div(word_t'(7), word_t'(2));
    add_div(-word_t'(7), word_t'(2));
    add_div(word_t'(7), -word_t'(2));
    add_div(-word_t'(7), -word_t'(2));
    add_div(word_t'(1), MOST_POS);
    add_div(ALL_ONES, word_t'(1));
    add_div(MOST_NEG, word_t'(2));
    add_div(word_t'(100), word_t'(7));
    add_div(ALL_ONES, ALL_ONES);
    // random part, with the odd overflow pair mixed in
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 49) == 0) add_div(MOST_NEG, ALL_ONES);
      else add_div(pick_operand(), pick_operand());
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_divs.size() != 0 || req_valid) @(posedge clk);
    while (expected_quotients.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
